### sv/jdcal_pkg.sv
// Shared constants, types and tables for the Julian day to calendar converter.
package jdcal_pkg;

	// Width of the binary day fraction used inside the converter.
	localparam int FRAC_BITS = 32;

	// Input field layout on the request bus.
	localparam int WHOLE_W  = 23;
	localparam int FRAC_IN_W = 32;
	localparam int WHOLE_LSB = 0;
	localparam int FRAC_LSB  = WHOLE_LSB + WHOLE_W;
	localparam int IN_W      = 56;

	// Output field layout on the result bus.
	localparam int YEAR_W    = 16;
	localparam int MONTH_W   = 4;
	localparam int DAY_W     = 5;
	localparam int HOURS_W   = 5;
	localparam int MINUTES_W = 6;
	localparam int MILLIS_W  = 16;
	localparam int YEAR_LSB    = 0;
	localparam int MONTH_LSB   = YEAR_LSB + YEAR_W;
	localparam int DAY_LSB     = MONTH_LSB + MONTH_W;
	localparam int HOURS_LSB   = DAY_LSB + DAY_W;
	localparam int MINUTES_LSB = HOURS_LSB + HOURS_W;
	localparam int MILLIS_LSB  = MINUTES_LSB + MINUTES_W;
	localparam int OUT_USED_W  = MILLIS_LSB + MILLIS_W;
	localparam int OUT_W       = 56;

	// Internal widths of the date path.
	localparam int Z_W      = 24;
	localparam int ALPHA_N_W = 25;
	localparam int ALPHA_W  = 8;
	localparam int CNUM_W   = 28;
	localparam int C_W      = 15;
	localparam int D_W      = 24;
	localparam int BD_W     = 10;
	localparam int P_W      = 24;
	localparam int E_W      = 4;
	localparam int MDAY_W   = 9;

	// First day number of the Gregorian calendar.
	localparam logic [Z_W-1:0] GREG_START = 24'd2299161;

	// 4 * 1867216.25, the offset of the century correction.
	localparam logic [Z_W+1:0] ALPHA_OFS = 26'd7468865;

	// Exact reciprocal of 146097 for numerators below 2^25.
	localparam int ALPHA_SH = 43;
	localparam int ALPHA_M_W = 26;
	localparam logic [ALPHA_M_W-1:0] ALPHA_M =
		ALPHA_M_W'((64'd1 << ALPHA_SH) / 64'd146097 + 64'd1);

	// Exact reciprocal of 7305 for numerators below 2^28.
	localparam int C_SH = 41;
	localparam int C_M_W = 29;
	localparam logic [C_M_W-1:0] C_M =
		C_M_W'((64'd1 << C_SH) / 64'd7305 + 64'd1);

	// Exact reciprocal of 306001 for numerators below 2^24.
	localparam int E_SH = 43;
	localparam int E_M_W = 25;
	localparam logic [E_M_W-1:0] E_M =
		E_M_W'((64'd1 << E_SH) / 64'd306001 + 64'd1);

	// Other date constants.
	localparam logic [Z_W-1:0]    B_OFS      = 24'd1524;
	localparam logic [CNUM_W-1:0] CNUM_MUL   = 28'd20;
	localparam logic [CNUM_W-1:0] CNUM_OFS   = 28'd2442;
	localparam logic [D_W+1:0]    D_MUL      = 26'd1461;
	localparam logic [P_W-1:0]    P_MUL      = 24'd10000;
	localparam logic [E_W-1:0]    E_WRAP     = 4'd14;
	localparam logic [E_W-1:0]    E_OFS_LOW  = 4'd1;
	localparam logic [E_W-1:0]    E_OFS_HIGH = 4'd13;
	localparam logic [MONTH_W-1:0] FEBRUARY  = 4'd2;
	localparam logic signed [YEAR_W-1:0] YEAR_OFS_EARLY = 16'sd4715;
	localparam logic signed [YEAR_W-1:0] YEAR_OFS_LATE  = 16'sd4716;

	// Clock constants.
	localparam int HOURS_PER_DAY = 24;
	localparam int MIN_PER_HOUR  = 60;
	localparam int MS_PER_MIN    = 60000;

	// floor(30.6001 * e) for every month index e.
	localparam logic [MDAY_W-1:0] MDAY_TAB [16] = '{
		9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd153, 9'd183, 9'd214,
		9'd244, 9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459
	};

	// Time of day as it travels down the pipeline.
	typedef struct packed {
		logic [MILLIS_W-1:0]  millis;
		logic [MINUTES_W-1:0] minutes;
		logic [HOURS_W-1:0]   hours;
	} clock_t;

endpackage

### sv/julian_day_to_calendar_core.sv
// Pipelined conversion of a Julian Date into calendar date and clock time.
//
// A request on the s_ group carries a whole Julian day count and a binary
// day fraction. The core adds half a day, applies the Meeus conversion with
// the Gregorian correction from day 2299161 on, and returns the astronomical
// year, month, day, hours, minutes and truncated milliseconds on the m_ group.
// Every division by a constant is done as an exact multiplication by a
// reciprocal, one multiplier per stage.
// Throughput: one request per cycle while the skid register is empty; the
// ten stage registers share one enable and each multiply by a reciprocal
// sits in a stage of its own.
// When the receiver stalls, the result in the last stage moves into a skid
// register and the pipe keeps moving once; while the skid register is full
// the whole pipe holds and s_tready is low. s_tready never depends on
// m_tready in the same cycle.
// Reset clears all valid bits, the skid flag among them; the core accepts a
// request in the first cycle after reset is released.
module julian_day_to_calendar_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// Fields from bit 0 up: jd_whole[22:0], jd_fraction[54:23], zero fill.
	input  logic [jdcal_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// Fields from bit 0 up: cal_year[15:0], cal_month[19:16], cal_day[24:20],
	// clock_hours[29:25], clock_minutes[35:30], clock_millis[51:36], zero fill.
	output logic [jdcal_pkg::OUT_W-1:0] m_tdata
);
	import jdcal_pkg::*;

	localparam int FB = FRAC_BITS;
	localparam logic [FB:0] HALF_DAY = (FB + 1)'(1) << (FB - 1);

	logic en;

	// Valid bits of the stages.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;

	// Date path registers.
	logic [Z_W-1:0]                 z_s1, z_s2, z_s3;
	logic                           greg_s2, greg_s3;
	logic [ALPHA_N_W-1:0]           anum_s2;
	logic [ALPHA_N_W+ALPHA_M_W-1:0] aprod_s3;
	logic [Z_W-1:0]                 b_s4, b_s5, b_s6;
	logic [CNUM_W-1:0]              cnum_s5;
	logic [CNUM_W+C_M_W-1:0]        cprod_s6;
	logic [C_W-1:0]                 c_s7, c_s8, c_s9;
	logic [BD_W-1:0]                bd_s7, bd_s8, bd_s9;
	logic [P_W-1:0]                 p_s8;
	logic [P_W+E_M_W-1:0]           eprod_s9;

	// Time path registers.
	logic [FB-1:0]                  f_s1;
	logic [FB+4:0]                  t24_s2;
	logic [FB+5:0]                  t60_s3;
	logic [HOURS_W-1:0]             hours_s3, hours_s4;
	logic [MINUTES_W-1:0]           minutes_s4;
	logic [FB+15:0]                 t60k_s4;
	clock_t                         clk_s5, clk_s6, clk_s7, clk_s8, clk_s9;

	// Result stage and skid register.
	logic signed [YEAR_W-1:0]       year_s10;
	logic [MONTH_W-1:0]             month_s10;
	logic [DAY_W-1:0]               day_s10;
	clock_t                         clk_s10;
	logic                           skid_vld_q;
	logic [OUT_W-1:0]               skid_data_q;
	logic [OUT_W-1:0]               res_word;

	// Combinational values inside the stages.
	logic [FB-1:0]    frac_in;
	logic [FB:0]      frac_sum;
	logic [ALPHA_W-1:0] alpha;
	logic [C_W-1:0]   c_val;
	logic [D_W+1:0]   d_full;
	logic [D_W-1:0]   d_val;
	logic [E_W-1:0]   e_val;
	logic [MONTH_W-1:0] month_val;

	// The pipe moves whenever the skid register is free.
	assign en       = !skid_vld_q;
	assign s_tready = en;

	// Valid bits shift with the pipe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else if (en) begin
			vld_s1  <= s_tvalid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
		end
	end

	// Stage 1 helpers: move the day start to midnight.
	assign frac_in  = FB'(s_tdata[FRAC_LSB +: FRAC_IN_W]);
	assign frac_sum = {1'b0, frac_in} + HALF_DAY;

	// Stage 4 helper: century correction term.
	assign alpha = aprod_s3[ALPHA_SH +: ALPHA_W];

	// Stage 7 helpers: year count and the days it covers.
	assign c_val  = cprod_s6[C_SH +: C_W];
	assign d_full = (D_W + 2)'(c_val) * D_MUL;
	assign d_val  = d_full[D_W+1:2];

	// Stage 10 helpers: month index and month.
	assign e_val     = eprod_s9[E_SH +: E_W];
	assign month_val = (e_val < E_WRAP) ? (e_val - E_OFS_LOW) : (e_val - E_OFS_HIGH);

	// Payload registers of all stages.
	always_ff @(posedge clk) begin
		if (en) begin
			// Stage 1: half-day carry into the day count.
			z_s1 <= Z_W'(s_tdata[WHOLE_LSB +: WHOLE_W]) + Z_W'(frac_sum[FB]);
			f_s1 <= frac_sum[FB-1:0];

			// Stage 2: Gregorian test and numerator of the correction; hours product.
			z_s2    <= z_s1;
			greg_s2 <= (z_s1 >= GREG_START);
			anum_s2 <= ALPHA_N_W'(((Z_W + 2)'(z_s1) << 2) - ALPHA_OFS);
			t24_s2  <= (FB + 5)'(f_s1) * (FB + 5)'(HOURS_PER_DAY);

			// Stage 3: divide by 146097; hours out, minutes product.
			z_s3     <= z_s2;
			greg_s3  <= greg_s2;
			aprod_s3 <= (ALPHA_N_W + ALPHA_M_W)'(anum_s2) *
				(ALPHA_N_W + ALPHA_M_W)'(ALPHA_M);
			hours_s3 <= t24_s2[FB +: HOURS_W];
			t60_s3   <= (FB + 6)'(t24_s2[FB-1:0]) * (FB + 6)'(MIN_PER_HOUR);

			// Stage 4: corrected day count plus the 1524 offset; minutes out, milliseconds product.
			if (greg_s3) begin
				b_s4 <= z_s3 + Z_W'(alpha) - Z_W'(alpha[ALPHA_W-1:2]) + Z_W'(1) + B_OFS;
			end else begin
				b_s4 <= z_s3 + B_OFS;
			end
			hours_s4   <= hours_s3;
			minutes_s4 <= t60_s3[FB +: MINUTES_W];
			t60k_s4    <= (FB + 16)'(t60_s3[FB-1:0]) * (FB + 16)'(MS_PER_MIN);

			// Stage 5: numerator of the year count; milliseconds out.
			b_s5           <= b_s4;
			cnum_s5        <= CNUM_W'(b_s4) * CNUM_MUL - CNUM_OFS;
			clk_s5.hours   <= hours_s4;
			clk_s5.minutes <= minutes_s4;
			clk_s5.millis  <= t60k_s4[FB +: MILLIS_W];

			// Stage 6: divide by 7305.
			b_s6     <= b_s5;
			cprod_s6 <= (CNUM_W + C_M_W)'(cnum_s5) * (CNUM_W + C_M_W)'(C_M);
			clk_s6   <= clk_s5;

			// Stage 7: days left in the year count.
			c_s7   <= c_val;
			bd_s7  <= BD_W'(b_s6 - d_val);
			clk_s7 <= clk_s6;

			// Stage 8: scale for the month division.
			c_s8   <= c_s7;
			bd_s8  <= bd_s7;
			p_s8   <= P_W'(bd_s7) * P_MUL;
			clk_s8 <= clk_s7;

			// Stage 9: divide by 306001.
			c_s9     <= c_s8;
			bd_s9    <= bd_s8;
			eprod_s9 <= (P_W + E_M_W)'(p_s8) * (P_W + E_M_W)'(E_M);
			clk_s9   <= clk_s8;

			// Stage 10: day, month and year.
			day_s10   <= DAY_W'(bd_s9 - BD_W'(MDAY_TAB[e_val]));
			month_s10 <= month_val;
			if (month_val > FEBRUARY) begin
				year_s10 <= $signed({1'b0, c_s9}) - YEAR_OFS_LATE;
			end else begin
				year_s10 <= $signed({1'b0, c_s9}) - YEAR_OFS_EARLY;
			end
			clk_s10 <= clk_s9;
		end
	end

	// Pack the last stage into the result word.
	assign res_word = {(OUT_W - OUT_USED_W)'(0), clk_s10.millis, clk_s10.minutes,
		clk_s10.hours, day_s10, month_s10, year_s10};

	// Skid register catches the last stage when the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (m_tready) begin
				skid_vld_q <= 1'b0;
			end
		end else if (vld_s10 && !m_tready) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_vld_q && vld_s10 && !m_tready) begin
			skid_data_q <= res_word;
		end
	end

	// Output side: the skid register has priority over the last stage.
	assign m_tvalid = skid_vld_q || vld_s10;
	assign m_tdata  = skid_vld_q ? skid_data_q : res_word;

	// The skid register fills only from a stalled result.
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(vld_s10 && !m_tready))
		else $error("skid register filled without a stalled result");

	// A held pipe keeps all of its valid bits.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable({vld_s1, vld_s2, vld_s3, vld_s4, vld_s5,
			vld_s6, vld_s7, vld_s8, vld_s9, vld_s10}))
		else $error("pipe moved while held");

	// Every delivered month is from 1 to 12 and every delivered day at least 1.
	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[MONTH_LSB +: MONTH_W] >= 4'd1) &&
			(m_tdata[MONTH_LSB +: MONTH_W] <= 4'd12) &&
			(m_tdata[DAY_LSB +: DAY_W] >= 5'd1))
		else $error("month or day out of range");

	// Every delivered time of day is in range.
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[HOURS_LSB +: HOURS_W] <= 5'd23) &&
			(m_tdata[MINUTES_LSB +: MINUTES_W] <= 6'd59) &&
			(m_tdata[MILLIS_LSB +: MILLIS_W] <= 16'd59999))
		else $error("time of day out of range");

endmodule
